FILE: rtl/bfdrx_pkg.sv
// ----------------------------------------------------------------------------
// bfdrx_pkg
// Types, constants and codes shared by the BFD session receive block.
// ----------------------------------------------------------------------------
package bfdrx_pkg;

	localparam int SESSIONS          = 16;
	localparam int SLOT_W            = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int MIN_PACKET_LENGTH = 24;
	localparam int DISCR_CNT_W       = 31;
	localparam logic [31:0] DISCR_LIMIT = 32'h7fff_ffff;
	localparam logic [4:0]  DIAG_NEIGHBOR_DOWN = 5'd3;
	localparam logic [2:0]  PROTO_VERSION = 3'd1;

	// Flag bit positions within flag_bits.
	localparam int FLAG_POLL  = 0;
	localparam int FLAG_FINAL = 1;
	localparam int FLAG_AUTH  = 3;
	localparam int FLAG_MPNT  = 4;

	typedef enum logic [1:0] {
		ST_ADMIN_DOWN = 2'd0,
		ST_DOWN       = 2'd1,
		ST_INIT       = 2'd2,
		ST_UP         = 2'd3
	} bfd_state_t;

	typedef enum logic [2:0] {
		STS_ACCEPTED   = 3'd0,
		STS_MALFORMED  = 3'd1,
		STS_NO_SESSION = 3'd2,
		STS_ADMIN_DOWN = 3'd3,
		STS_CREATED    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_DESIRED_TX  = 2'd0,
		CFG_REQUIRED_RX = 2'd1,
		CFG_INITIAL_RX  = 2'd2,
		CFG_DETECT_MULT = 2'd3
	} cfg_reg_t;

	localparam logic [31:0] DESIRED_TX_RESET = 32'd1000000;

	typedef struct packed {
		logic [3:0]  peer_index;
		logic [7:0]  packet_length;
		logic [2:0]  version;
		bfd_state_t  remote_state;
		logic [4:0]  flag_bits;
		logic [7:0]  remote_detect_mult;
		logic [31:0] sender_discr;
		logic [31:0] receiver_discr;
		logic [31:0] remote_min_rx;
		logic [47:0] now_us;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		bfd_state_t  link_state;
		logic [4:0]  diag_code;
		logic [47:0] detect_deadline;
		logic        reply_send;
		bfd_state_t  reply_state;
		logic        reply_final;
		logic [31:0] reply_my_discr;
		logic [31:0] reply_your_discr;
	} out_item_t;

	// One session slot as held in the table.
	typedef struct packed {
		logic        valid;
		logic        attached;
		bfd_state_t  state;
		logic [4:0]  diag;
		logic [31:0] own_discr;
		logic [47:0] deadline;
	} slot_t;

	// Updates produced by one packet for the table and the discriminator counter.
	typedef struct packed {
		logic                   slot_we;
		logic [SLOT_W-1:0]      slot_idx;
		slot_t                  slot_wd;
		logic                   cnt_we;
		logic [DISCR_CNT_W-1:0] cnt_next;
	} upd_t;

endpackage

FILE: rtl/bfdrx_slot_table.sv
// ----------------------------------------------------------------------------
// bfdrx_slot_table
// Per-session slot storage with one combinational read and one write port.
// ----------------------------------------------------------------------------
module bfdrx_slot_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [bfdrx_pkg::SLOT_W-1:0] rd_idx,
	output bfdrx_pkg::slot_t        rd_data,
	input  logic                    we,
	input  logic [bfdrx_pkg::SLOT_W-1:0] wr_idx,
	input  bfdrx_pkg::slot_t        wr_data
);
	import bfdrx_pkg::*;

	logic  valid_q [SESSIONS];
	slot_t entry_q [SESSIONS];

	// Only the valid bits are cleared; an invalid entry is never used for its contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SESSIONS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (we) begin
			valid_q[wr_idx] <= wr_data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			entry_q[wr_idx] <= wr_data;
		end
	end

	always_comb begin
		rd_data       = entry_q[rd_idx];
		rd_data.valid = valid_q[rd_idx];
	end

endmodule

FILE: rtl/bfdrx_step.sv
// ----------------------------------------------------------------------------
// bfdrx_step
// Validates one control packet, steps the session state machine and
// forms the result and the slot update.
// ----------------------------------------------------------------------------
module bfdrx_step (
	input  bfdrx_pkg::in_item_t              item,
	input  bfdrx_pkg::slot_t                 slot_rd,
	input  logic [bfdrx_pkg::DISCR_CNT_W-1:0] discr_cnt,
	input  logic [31:0]                      desired_tx,
	output bfdrx_pkg::out_item_t             res,
	output bfdrx_pkg::upd_t                  upd
);
	import bfdrx_pkg::*;

	logic        malformed;
	logic        out_of_range;
	slot_t       cur;
	bfd_state_t  st_next;
	logic [4:0]  diag_next;
	logic [31:0] cnt_inc;
	logic [31:0] own_discr;
	logic [31:0] rx_max;
	logic [39:0] prod;
	logic [47:0] deadline;
	bfd_state_t  rep_state;

	assign malformed = (item.packet_length != 8'(MIN_PACKET_LENGTH))
		|| item.flag_bits[FLAG_MPNT] || (item.version != PROTO_VERSION)
		|| item.flag_bits[FLAG_AUTH] || (item.sender_discr == '0)
		|| (item.remote_detect_mult == '0)
		|| ((item.receiver_discr == '0) && !(item.remote_state == ST_DOWN
			|| item.remote_state == ST_ADMIN_DOWN));

	assign out_of_range = (32'(item.peer_index) >= 32'(SESSIONS));

	// An empty slot entered by a down packet starts from a fresh down session.
	always_comb begin
		if (slot_rd.valid) begin
			cur = slot_rd;
		end else begin
			cur             = '0;
			cur.valid       = 1'b1;
			cur.state       = ST_DOWN;
		end
	end

	assign cnt_inc     = {1'b0, discr_cnt} + 32'd1;
	assign own_discr   = cur.attached ? cur.own_discr : cnt_inc;
	assign rx_max      = (item.remote_min_rx > desired_tx) ? item.remote_min_rx : desired_tx;
	assign prod        = 40'(item.remote_detect_mult) * 40'(rx_max);
	assign deadline    = item.now_us + 48'(prod);

	// Next session state.
	always_comb begin
		st_next   = cur.state;
		diag_next = cur.diag;
		if (item.remote_state == ST_ADMIN_DOWN) begin
			if (cur.state != ST_DOWN) begin
				st_next   = ST_DOWN;
				diag_next = DIAG_NEIGHBOR_DOWN;
			end
		end else begin
			unique case (cur.state)
				ST_DOWN: begin
					if (item.remote_state == ST_DOWN) begin
						st_next = ST_INIT;
					end else if (item.remote_state == ST_INIT) begin
						st_next = ST_UP;
					end
				end
				ST_INIT: begin
					st_next = (item.remote_state == ST_INIT || item.remote_state == ST_UP)
						? ST_UP : ST_DOWN;
				end
				default: begin
					if (item.remote_state == ST_DOWN) begin
						st_next   = ST_DOWN;
						diag_next = DIAG_NEIGHBOR_DOWN;
					end
				end
			endcase
		end
	end

	assign rep_state = (own_discr != '0) ? st_next : ST_DOWN;

	// Result and table updates.
	always_comb begin
		res          = '0;
		upd          = '0;
		upd.slot_idx = SLOT_W'(item.peer_index);
		upd.cnt_next = (cnt_inc > DISCR_LIMIT) ? '0 : cnt_inc[DISCR_CNT_W-1:0];
		if (malformed) begin
			res.status = STS_MALFORMED;
		end else if (out_of_range) begin
			res.status = STS_NO_SESSION;
		end else if (!slot_rd.valid && (item.receiver_discr != '0)) begin
			upd.slot_we                 = 1'b1;
			upd.slot_wd                 = '0;
			upd.slot_wd.valid           = 1'b1;
			upd.slot_wd.state           = ST_DOWN;
			upd.slot_wd.own_discr       = item.receiver_discr;
			res.status                  = STS_CREATED;
			res.link_state              = ST_DOWN;
		end else if (!slot_rd.valid && (item.remote_state != ST_DOWN)) begin
			res.status = STS_NO_SESSION;
		end else begin
			upd.cnt_we = !cur.attached;
			if (cur.state == ST_ADMIN_DOWN) begin
				res.status          = STS_ADMIN_DOWN;
				res.link_state      = cur.state;
				res.diag_code       = cur.diag;
				res.detect_deadline = cur.deadline;
			end else begin
				upd.slot_we                 = 1'b1;
				upd.slot_wd.valid           = 1'b1;
				upd.slot_wd.attached        = 1'b1;
				upd.slot_wd.state           = st_next;
				upd.slot_wd.diag            = diag_next;
				upd.slot_wd.own_discr       = own_discr;
				upd.slot_wd.deadline        = deadline;
				res.status                  = STS_ACCEPTED;
				res.link_state              = st_next;
				res.diag_code               = diag_next;
				res.detect_deadline         = deadline;
				if (item.flag_bits[FLAG_POLL] && !(((item.sender_discr == '0)
					|| (own_discr == '0)) && (rep_state != ST_DOWN))) begin
					res.reply_send       = 1'b1;
					res.reply_state      = rep_state;
					res.reply_final      = 1'b1;
					res.reply_my_discr   = own_discr;
					res.reply_your_discr = item.sender_discr;
				end
			end
		end
	end

endmodule

FILE: rtl/bfd_session_receive_fsm_top.sv
// ----------------------------------------------------------------------------
// bfd_session_receive_fsm_top
// BFD control packet receive path: session lookup, state machine and replies.
// ----------------------------------------------------------------------------
// One decoded control packet is accepted per cycle while in_ready is high.
// The packet is captured in an input register, the 16-entry session table
// is read, updated and written back as the packet leaves that register, and
// the result lands in an output register. The read-modify-write of the
// session slot completes as each packet advances, so back-to-back packets
// to the same slot see each other's updates. A stalled output backs up one
// packet in the input register before in_ready drops. The session table
// needs no clearing pass after reset. Only the desired transmit interval
// register affects results; writes to the other registers are accepted and
// have no effect on the outputs.
module bfd_session_receive_fsm_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bfdrx_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bfdrx_pkg::out_item_t out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import bfdrx_pkg::*;

	logic                   valid_s1;
	in_item_t               item_s1;
	logic                   valid_s2;
	out_item_t              res_s2;
	logic                   adv;
	logic [31:0]            desired_tx_q;
	logic [DISCR_CNT_W-1:0] discr_cnt_q;
	slot_t                  slot_rd;
	out_item_t              res;
	upd_t                   upd;

	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_item  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desired_tx_q <= DESIRED_TX_RESET;
		end else if (cfg_valid && (cfg_index == CFG_DESIRED_TX)) begin
			desired_tx_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			discr_cnt_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (adv && upd.cnt_we) begin
				discr_cnt_q <= upd.cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	bfdrx_slot_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (SLOT_W'(item_s1.peer_index)),
		.rd_data (slot_rd),
		.we      (adv && upd.slot_we),
		.wr_idx  (upd.slot_idx),
		.wr_data (upd.slot_wd)
	);

	bfdrx_step u_step (
		.item       (item_s1),
		.slot_rd    (slot_rd),
		.discr_cnt  (discr_cnt_q),
		.desired_tx (desired_tx_q),
		.res        (res),
		.upd        (upd)
	);

	// The discriminator counter wraps before leaving the 31-bit range.
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && upd.cnt_we |=> (32'(discr_cnt_q) <= DISCR_LIMIT))
		else $error("discriminator counter out of range");

	// Rejected packets carry nothing but their status.
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.status == STS_MALFORMED || res_s2.status == STS_NO_SESSION)
		|-> (res_s2.detect_deadline == '0) && !res_s2.reply_send
			&& (res_s2.reply_my_discr == '0) && (res_s2.link_state == ST_ADMIN_DOWN))
		else $error("rejected packet result carries data");

	// A reply only follows an accepted packet and always has the final bit.
	a_reply: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.reply_send
		|-> res_s2.reply_final && (res_s2.status == STS_ACCEPTED))
		else $error("reply on a non-accepted packet or without final");

	// The input side only stalls when both stages are full and the output is blocked.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled with room in the pipeline");

	// A slot written on acceptance is read back as valid by the next packet to it.
	a_slot_written: assert property (@(posedge clk) disable iff (!arst_n)
		adv && upd.slot_we && in_valid && in_ready
		&& (SLOT_W'(in_item.peer_index) == upd.slot_idx) |=> slot_rd.valid)
		else $error("slot write lost");

endmodule
